[design/convolutional_encoder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the convolutional encoder
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef CONVOLUTIONAL_ENCODER_ASSERT_SVH
`define CONVOLUTIONAL_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
// check on clk_i, ignored while rst_ni is low
`define CE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on clk_i that also holds during reset
`define CE_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CE_ASSERT(lbl, prop, msg)
`define CE_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

[design/ce_pkg.sv]
// ---------------------------------------------------------------------------
// Convolutional encoder package
// Shared widths, register indexes, reset values and payload types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ce_pkg;

  // default limits of the top-level parameters
  localparam int SYMBOL_BITS_MAX_DEF = 4;
  localparam int MEMORY_MAX_DEF      = 8;
  localparam int OUTPUTS_MAX_DEF     = 4;

  // fixed field and register widths
  localparam int GEN_COUNT  = 4;
  localparam int GEN_W      = 36;
  localparam int SYMBOL_W   = 4;
  localparam int CODE_W     = 4;
  localparam int K_REG_W    = 3;
  localparam int M_REG_W    = 4;
  localparam int N_REG_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;

  // clamped layout values, wide enough for the largest parameter settings
  localparam int K_EFF_W = 4;
  localparam int M_EFF_W = 5;
  localparam int N_EFF_W = 3;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BITS_PER_SYMBOL = 3'd0,
    CFG_MEMORY_DEPTH    = 3'd1,
    CFG_OUTPUT_COUNT    = 3'd2,
    CFG_GENERATOR_0     = 3'd3,
    CFG_GENERATOR_1     = 3'd4,
    CFG_GENERATOR_2     = 3'd5,
    CFG_GENERATOR_3     = 3'd6
  } cfg_idx_e;

  // reset values
  localparam logic [K_REG_W-1:0] K_RESET     = 3'd1;
  localparam logic [M_REG_W-1:0] M_RESET     = 4'd2;
  localparam logic [N_REG_W-1:0] N_RESET     = 3'd2;
  localparam logic [GEN_W-1:0]   GEN0_RESET  = 36'd7;
  localparam logic [GEN_W-1:0]   GEN1_RESET  = 36'd5;
  localparam logic [GEN_W-1:0]   GEN2_RESET  = 36'd1;
  localparam logic [GEN_W-1:0]   GEN3_RESET  = 36'd1;

  // input item
  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                first;
    logic                final_symbol;
  } ce_in_t;

  // result item
  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic              end_of_frame;
  } ce_out_t;

  // clamped code layout
  typedef struct packed {
    logic [K_EFF_W-1:0] k;
    logic [M_EFF_W-1:0] m;
    logic [N_EFF_W-1:0] n;
  } ce_layout_t;

  // per-step control broadcast to the cells
  typedef struct packed {
    logic                step;
    logic                clear;
    logic [SYMBOL_W-1:0] symbol;
  } ce_step_t;

endpackage

[design/ce_cfg.sv]
// ---------------------------------------------------------------------------
// Convolutional encoder configuration registers
// Register file for k, m, n and the generator masks, with range clamping.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce_cfg #(
  parameter int SYMBOL_BITS_MAX = ce_pkg::SYMBOL_BITS_MAX_DEF,
  parameter int MEMORY_MAX      = ce_pkg::MEMORY_MAX_DEF,
  parameter int OUTPUTS_MAX     = ce_pkg::OUTPUTS_MAX_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             cfg_we_i,
  input  logic [ce_pkg::CFG_IDX_W-1:0]                     cfg_index_i,
  input  logic [ce_pkg::CFG_DATA_W-1:0]                    cfg_data_i,
  output ce_pkg::ce_layout_t                               layout_o,
  output logic [ce_pkg::GEN_COUNT-1:0][ce_pkg::GEN_W-1:0]  gen_o
);

  localparam int N_LIMIT = (OUTPUTS_MAX < ce_pkg::GEN_COUNT) ? OUTPUTS_MAX
                                                             : ce_pkg::GEN_COUNT;

  logic [ce_pkg::K_REG_W-1:0]                     k_q;
  logic [ce_pkg::M_REG_W-1:0]                     m_q;
  logic [ce_pkg::N_REG_W-1:0]                     n_q;
  logic [ce_pkg::GEN_COUNT-1:0][ce_pkg::GEN_W-1:0] gen_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= ce_pkg::K_RESET;
      m_q      <= ce_pkg::M_RESET;
      n_q      <= ce_pkg::N_RESET;
      gen_q[0] <= ce_pkg::GEN0_RESET;
      gen_q[1] <= ce_pkg::GEN1_RESET;
      gen_q[2] <= ce_pkg::GEN2_RESET;
      gen_q[3] <= ce_pkg::GEN3_RESET;
    end else if (cfg_we_i) begin
      unique case (ce_pkg::cfg_idx_e'(cfg_index_i))
        ce_pkg::CFG_BITS_PER_SYMBOL: k_q      <= cfg_data_i[ce_pkg::K_REG_W-1:0];
        ce_pkg::CFG_MEMORY_DEPTH:    m_q      <= cfg_data_i[ce_pkg::M_REG_W-1:0];
        ce_pkg::CFG_OUTPUT_COUNT:    n_q      <= cfg_data_i[ce_pkg::N_REG_W-1:0];
        ce_pkg::CFG_GENERATOR_0:     gen_q[0] <= cfg_data_i[ce_pkg::GEN_W-1:0];
        ce_pkg::CFG_GENERATOR_1:     gen_q[1] <= cfg_data_i[ce_pkg::GEN_W-1:0];
        ce_pkg::CFG_GENERATOR_2:     gen_q[2] <= cfg_data_i[ce_pkg::GEN_W-1:0];
        ce_pkg::CFG_GENERATOR_3:     gen_q[3] <= cfg_data_i[ce_pkg::GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported ranges
  always_comb begin
    if (k_q == '0) begin
      layout_o.k = ce_pkg::K_EFF_W'(1);
    end else if (ce_pkg::K_EFF_W'(k_q) > ce_pkg::K_EFF_W'(SYMBOL_BITS_MAX)) begin
      layout_o.k = ce_pkg::K_EFF_W'(SYMBOL_BITS_MAX);
    end else begin
      layout_o.k = ce_pkg::K_EFF_W'(k_q);
    end

    if (m_q == '0) begin
      layout_o.m = ce_pkg::M_EFF_W'(1);
    end else if (ce_pkg::M_EFF_W'(m_q) > ce_pkg::M_EFF_W'(MEMORY_MAX)) begin
      layout_o.m = ce_pkg::M_EFF_W'(MEMORY_MAX);
    end else begin
      layout_o.m = ce_pkg::M_EFF_W'(m_q);
    end

    if (n_q == '0) begin
      layout_o.n = ce_pkg::N_EFF_W'(1);
    end else if (ce_pkg::N_EFF_W'(n_q) > ce_pkg::N_EFF_W'(N_LIMIT)) begin
      layout_o.n = ce_pkg::N_EFF_W'(N_LIMIT);
    end else begin
      layout_o.n = ce_pkg::N_EFF_W'(n_q);
    end
  end

  assign gen_o = gen_q;

endmodule

[design/ce_cell.sv]
// ---------------------------------------------------------------------------
// Convolutional encoder shift cell
// One bit of the shift state: finds its stream and delay from the layout,
// shifts in from its left neighbor or the input, and gives its parity taps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce_cell #(
  parameter int SYMBOL_BITS_MAX = ce_pkg::SYMBOL_BITS_MAX_DEF,
  parameter int MEMORY_MAX      = ce_pkg::MEMORY_MAX_DEF,
  parameter int POS             = 0
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  ce_pkg::ce_step_t                                 ctrl_i,
  input  ce_pkg::ce_layout_t                               layout_i,
  input  logic [ce_pkg::GEN_COUNT-1:0][ce_pkg::GEN_W-1:0]  gen_i,
  input  logic                                             left_i,
  output logic                                             eff_o,
  output logic [ce_pkg::GEN_COUNT-1:0]                     tap_o
);

  localparam int STATE_W = SYMBOL_BITS_MAX * MEMORY_MAX;
  localparam int PW      = $clog2(STATE_W + 1);
  localparam int REG_W   = SYMBOL_BITS_MAX * (MEMORY_MAX + 1);
  localparam int TAP_W   = (REG_W > ce_pkg::GEN_W) ? REG_W : ce_pkg::GEN_W;
  localparam int IW      = (TAP_W > 1) ? $clog2(TAP_W) : 1;

  logic                                   state_q, state_d;
  logic [SYMBOL_BITS_MAX+ce_pkg::SYMBOL_W-1:0] sym_wide;
  logic                                   active, head, in_bit, in_val, st_eff;
  logic [IW-1:0]                          idx_in, idx_st;
  logic [ce_pkg::GEN_COUNT-1:0][TAP_W-1:0] gen_ext;

  assign sym_wide = {{SYMBOL_BITS_MAX{1'b0}}, ctrl_i.symbol};

  // locate this bit: stream s holds positions s*m .. s*m+m-1
  always_comb begin : locate
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    active = 1'b0;
    head   = 1'b0;
    in_bit = 1'b0;
    idx_in = '0;
    idx_st = '0;
    lo     = '0;
    hi     = '0;
    for (int s = 0; s < SYMBOL_BITS_MAX; s++) begin
      lo = PW'(s) * PW'(layout_i.m);
      hi = lo + PW'(layout_i.m);
      if ((ce_pkg::K_EFF_W'(s) < layout_i.k) && (PW'(POS) >= lo) && (PW'(POS) < hi)) begin
        active = 1'b1;
        head   = (PW'(POS) == lo);
        in_bit = sym_wide[s];
        // combined register: input bit at s*(m+1), delay d at s*(m+1)+d
        idx_in = IW'(POS + s);
        idx_st = IW'(POS + s + 1);
      end
    end
  end

  // generator taps, zero-extended above the generator width
  always_comb begin
    for (int i = 0; i < ce_pkg::GEN_COUNT; i++) begin
      gen_ext[i] = TAP_W'(gen_i[i]);
    end
  end

  assign in_val = head & in_bit;
  assign st_eff = state_q & active & ~ctrl_i.clear;
  assign eff_o  = st_eff;

  always_comb begin
    for (int i = 0; i < ce_pkg::GEN_COUNT; i++) begin
      tap_o[i] = (st_eff & gen_ext[i][idx_st]) ^ (in_val & gen_ext[i][idx_in]);
    end
  end

  // shift: the head of a stream loads the input bit
  assign state_d = active & (head ? in_val : left_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
    end else if (ctrl_i.step) begin
      state_q <= state_d;
    end
  end

endmodule

[design/convolutional_encoder.sv]
// ---------------------------------------------------------------------------
// Convolutional encoder
// Feedforward k/n encoder with m memory stages per stream, built as a row of
// one-bit shift cells with a registered result stage.
// ---------------------------------------------------------------------------
// Latency: a result is valid on the cycle after its input transfer.
// Throughput: one symbol per cycle while the output is not stalled; a symbol with
//   final_symbol set is followed by m tail steps (m = memory_depth) that stall the input.
// The step rate is set by the output stall and the tail counter.
// Reset: asynchronous; shift state cleared, registers to their reset values.
`timescale 1ns / 1ps

`include "convolutional_encoder_assert.svh"

module convolutional_encoder #(
  parameter int SYMBOL_BITS_MAX = ce_pkg::SYMBOL_BITS_MAX_DEF,
  parameter int MEMORY_MAX      = ce_pkg::MEMORY_MAX_DEF,
  parameter int OUTPUTS_MAX     = ce_pkg::OUTPUTS_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input symbols
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ce_pkg::ce_in_t                in_i,
  // code results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ce_pkg::ce_out_t               out_o
);

  localparam int STATE_W = SYMBOL_BITS_MAX * MEMORY_MAX;
  localparam int TW      = $clog2(MEMORY_MAX + 1);

  ce_pkg::ce_layout_t                              layout;
  logic [ce_pkg::GEN_COUNT-1:0][ce_pkg::GEN_W-1:0] gen;
  ce_pkg::ce_step_t                                ctrl;

  logic                                      tail_idle, load_ok, in_xfer, step;
  logic [TW-1:0]                             tail_q, tail_d, m_tail;
  logic                                      out_valid_q, out_valid_d;
  ce_pkg::ce_out_t                           out_q, out_d;
  logic [STATE_W-1:0]                        eff;
  logic [STATE_W-1:0][ce_pkg::GEN_COUNT-1:0] taps;
  logic [ce_pkg::GEN_COUNT-1:0]              code_raw;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  ce_cfg #(
    .SYMBOL_BITS_MAX (SYMBOL_BITS_MAX),
    .MEMORY_MAX      (MEMORY_MAX),
    .OUTPUTS_MAX     (OUTPUTS_MAX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .layout_o    (layout),
    .gen_o       (gen)
  );

  // step control: input transfer or a tail step, whenever the result slot frees
  assign m_tail     = TW'(layout.m);
  assign tail_idle  = (tail_q == '0);
  assign load_ok    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~(load_ok & tail_idle);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign step       = in_xfer | (~tail_idle & load_ok);

  assign ctrl.step   = step;
  assign ctrl.clear  = tail_idle & in_i.first;
  assign ctrl.symbol = tail_idle ? in_i.symbol : '0;

  always_comb begin
    tail_d = tail_q;
    if (in_xfer && in_i.final_symbol) begin
      tail_d = m_tail;
    end else if (!tail_idle && load_ok) begin
      tail_d = tail_q - TW'(1);
    end
  end

  // row of shift cells
  for (genvar p = 0; p < STATE_W; p++) begin : g_cell
    logic left;
    if (p == 0) begin : g_first
      assign left = 1'b0;
    end else begin : g_next
      assign left = eff[p-1];
    end

    ce_cell #(
      .SYMBOL_BITS_MAX (SYMBOL_BITS_MAX),
      .MEMORY_MAX      (MEMORY_MAX),
      .POS             (p)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .layout_i (layout),
      .gen_i    (gen),
      .left_i   (left),
      .eff_o    (eff[p]),
      .tap_o    (taps[p])
    );
  end

  // parity of the taps over the row
  always_comb begin
    code_raw = '0;
    for (int p = 0; p < STATE_W; p++) begin
      code_raw = code_raw ^ taps[p];
    end
  end

  // result register
  always_comb begin
    out_d = out_q;
    for (int i = 0; i < ce_pkg::GEN_COUNT; i++) begin
      out_d.code_bits[i] = code_raw[i] & (ce_pkg::N_EFF_W'(i) < layout.n);
    end
    out_d.end_of_frame = (tail_q == TW'(1));
    if (step) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  `CE_ASSERT_NORST(a_tail_bound, tail_q <= TW'(MEMORY_MAX), "tail count out of range")
  `CE_ASSERT(a_tail_stalls, (tail_q != '0) |-> in_stall_o, "input taken during tail")
  `CE_ASSERT(a_tail_load, (in_xfer && in_i.final_symbol) |=> (tail_q == $past(m_tail)), "tail count not loaded")
  `CE_ASSERT(a_eof_last, (step && tail_q == TW'(1)) |=> (out_valid_q && out_q.end_of_frame), "missing end of frame")
  `CE_ASSERT(a_eof_only_tail, (step && tail_q == '0) |=> !out_q.end_of_frame, "end of frame on data step")

endmodule
